@@ rtl/ccpe_pkg.sv @@
// ----------------------------------------------------------------------------
// ccpe_pkg: shared constants, basis matrices and helpers
// Basis codes, derivative order codes, Q.16 basis coefficient table and the
// coefficient lookup used by the cubic curve point evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package ccpe_pkg;

	// Default widths for the top level parameters
	localparam int COORD_WIDTH_DEF     = 16;
	localparam int PARAM_FRAC_BITS_DEF = 16;

	// Fixed-point layout of the constant matrices and the weights
	localparam int MAT_FRAC     = 16;
	localparam int COEF_W       = 22;
	localparam int WEIGHT_W     = 31;
	localparam int WEIGHT_LIMIT = 1 << 29;
	localparam int VALUE_W      = 32;
	localparam int BASIS_W      = 3;
	localparam int NUM_BASES    = 5;

	// Basis matrix codes
	typedef enum logic [BASIS_W-1:0] {
		BASIS_INTERP  = 3'd0,
		BASIS_HERMITE = 3'd1,
		BASIS_BEZIER  = 3'd2,
		BASIS_CATMULL = 3'd3,
		BASIS_BSPLINE = 3'd4
	} basis_t;

	// Derivative order codes; anything above first is treated as second
	localparam logic [1:0] ORDER_POSITION = 2'd0;
	localparam logic [1:0] ORDER_FIRST    = 2'd1;

	// Basis matrices in Q.16, indexed [basis][power row][control point]
	localparam int BASIS_TAB [NUM_BASES][4][4] = '{
		'{ '{ -294912,   884736,  -884736,  294912 },
		   '{  589824, -1474560,  1179648, -294912 },
		   '{ -360448,   589824,  -294912,   65536 },
		   '{   65536,        0,        0,       0 } },
		'{ '{  131072,  -131072,    65536,   65536 },
		   '{ -196608,   196608,  -131072,  -65536 },
		   '{       0,        0,    65536,       0 },
		   '{   65536,        0,        0,       0 } },
		'{ '{  -65536,   196608,  -196608,   65536 },
		   '{  196608,  -393216,   196608,       0 },
		   '{ -196608,   196608,        0,       0 },
		   '{   65536,        0,        0,       0 } },
		'{ '{  -32768,    98304,   -98304,   32768 },
		   '{   65536,  -163840,   131072,  -32768 },
		   '{  -32768,        0,    32768,       0 },
		   '{       0,    65536,        0,       0 } },
		'{ '{  -10923,    32768,   -32768,   10923 },
		   '{   32768,   -65536,    32768,       0 },
		   '{  -32768,        0,    32768,       0 },
		   '{   10923,    43691,    10923,       0 } }
	};

	// Look up one coefficient; unused basis codes fall back to the B-spline
	function automatic logic signed [COEF_W-1:0] basis_coef(
		input logic [BASIS_W-1:0] sel,
		input logic [1:0]         row,
		input logic [1:0]         col
	);
		basis_t k;
		k = (sel > BASIS_BSPLINE) ? BASIS_BSPLINE : basis_t'(sel);
		return COEF_W'(BASIS_TAB[k][row][col]);
	endfunction

endpackage

`default_nettype wire

@@ rtl/ccpe_power.sv @@
// ----------------------------------------------------------------------------
// ccpe_power: power vector stages
// Squares and cubes the curve parameter with rounding and builds the power
// vector for the requested derivative order over three pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpe_power #(
	parameter int COORD_WIDTH     = ccpe_pkg::COORD_WIDTH_DEF,
	parameter int PARAM_FRAC_BITS = ccpe_pkg::PARAM_FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                up_valid,
	output logic                                     up_ready,
	input  wire logic [PARAM_FRAC_BITS:0]            param_u,
	input  wire logic [1:0]                          deriv_order,
	input  wire logic signed [COORD_WIDTH-1:0]       coord [4],
	input  wire logic [ccpe_pkg::BASIS_W-1:0]        basis_sel,
	output logic                                     dn_valid,
	input  wire logic                                dn_ready,
	output logic signed [PARAM_FRAC_BITS+4:0]        uv [4],
	output logic signed [COORD_WIDTH-1:0]            coord_out [4],
	output logic [ccpe_pkg::BASIS_W-1:0]             basis_out
);

	localparam int F   = PARAM_FRAC_BITS;
	localparam int UW  = F + 1;
	localparam int SQW = 2 * F + 2;
	localparam int U2W = F + 2;
	localparam int CBW = 2 * F + 3;
	localparam int U3W = F + 3;
	localparam int VW  = F + 5;

	localparam logic [SQW:0]         SQ_HALF = (SQW + 1)'(1) << (F - 1);
	localparam logic [CBW:0]         CB_HALF = (CBW + 1)'(1) << (F - 1);
	localparam logic signed [VW-1:0] ONE_V   = VW'(1) << F;

	logic en_s1, en_s2, en_s3;
	logic v_s1, v_s2, v_s3;

	logic [SQW-1:0]                usq_s1;
	logic [UW-1:0]                 u_s1;
	logic [1:0]                    order_s1;
	logic signed [COORD_WIDTH-1:0] coord_s1 [4];
	logic [ccpe_pkg::BASIS_W-1:0]  basis_s1;

	logic [SQW:0]                  usq_rnd;
	logic [U2W-1:0]                u2_d;
	logic [U2W-1:0]                u2_s2;
	logic [CBW-1:0]                cube_s2;
	logic [UW-1:0]                 u_s2;
	logic [1:0]                    order_s2;
	logic signed [COORD_WIDTH-1:0] coord_s2 [4];
	logic [ccpe_pkg::BASIS_W-1:0]  basis_s2;

	logic [CBW:0]                  cube_rnd;
	logic [U3W-1:0]                u3_d;
	logic signed [VW-1:0]          uv_d [4];
	logic signed [VW-1:0]          uv_s3 [4];
	logic signed [COORD_WIDTH-1:0] coord_s3 [4];
	logic [ccpe_pkg::BASIS_W-1:0]  basis_s3;

	// Stage enables: advance when empty or when the next stage advances
	assign en_s3    = !v_s3 || dn_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign up_ready = en_s1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= up_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Stage 1: square the parameter
	always_ff @(posedge clk) begin
		if (en_s1) begin
			usq_s1   <= SQW'(param_u) * SQW'(param_u);
			u_s1     <= param_u;
			order_s1 <= deriv_order;
			coord_s1 <= coord;
			basis_s1 <= basis_sel;
		end
	end

	// Stage 2: round the square, then multiply by u for the cube
	assign usq_rnd = {1'b0, usq_s1} + SQ_HALF;
	assign u2_d    = U2W'(usq_rnd >> F);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			u2_s2    <= u2_d;
			cube_s2  <= CBW'(u2_d) * CBW'(u_s1);
			u_s2     <= u_s1;
			order_s2 <= order_s1;
			coord_s2 <= coord_s1;
			basis_s2 <= basis_s1;
		end
	end

	// Stage 3: round the cube and select the power vector for the order
	assign cube_rnd = {1'b0, cube_s2} + CB_HALF;
	assign u3_d     = U3W'(cube_rnd >> F);

	always_comb begin
		case (order_s2)
			ccpe_pkg::ORDER_POSITION: begin
				uv_d[0] = VW'(u3_d);
				uv_d[1] = VW'(u2_s2);
				uv_d[2] = VW'(u_s2);
				uv_d[3] = ONE_V;
			end
			ccpe_pkg::ORDER_FIRST: begin
				uv_d[0] = VW'(u2_s2) + (VW'(u2_s2) << 1);
				uv_d[1] = VW'(u_s2) << 1;
				uv_d[2] = ONE_V;
				uv_d[3] = '0;
			end
			default: begin
				uv_d[0] = (VW'(u_s2) << 2) + (VW'(u_s2) << 1);
				uv_d[1] = ONE_V << 1;
				uv_d[2] = '0;
				uv_d[3] = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			uv_s3    <= uv_d;
			coord_s3 <= coord_s2;
			basis_s3 <= basis_s2;
		end
	end

	assign dn_valid  = v_s3;
	assign uv        = uv_s3;
	assign coord_out = coord_s3;
	assign basis_out = basis_s3;

endmodule

`default_nettype wire

@@ rtl/ccpe_weight.sv @@
// ----------------------------------------------------------------------------
// ccpe_weight: basis weight stages
// Multiplies the power vector by the selected basis matrix, one product per
// matrix entry, then sums, rounds and clamps the four control point weights.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpe_weight #(
	parameter int COORD_WIDTH     = ccpe_pkg::COORD_WIDTH_DEF,
	parameter int PARAM_FRAC_BITS = ccpe_pkg::PARAM_FRAC_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   up_valid,
	output logic                                        up_ready,
	input  wire logic signed [PARAM_FRAC_BITS+4:0]      uv [4],
	input  wire logic signed [COORD_WIDTH-1:0]          coord [4],
	input  wire logic [ccpe_pkg::BASIS_W-1:0]           basis_sel,
	output logic                                        dn_valid,
	input  wire logic                                   dn_ready,
	output logic signed [ccpe_pkg::WEIGHT_W-1:0]        weight [4],
	output logic signed [COORD_WIDTH-1:0]               coord_out [4]
);

	localparam int F  = PARAM_FRAC_BITS;
	localparam int VW = F + 5;
	localparam int PW = VW + ccpe_pkg::COEF_W;
	localparam int SW = PW + 2;
	localparam int WW = ccpe_pkg::WEIGHT_W;

	localparam logic signed [SW-1:0] W_HALF = SW'(1) <<< (F - 1);
	localparam logic signed [SW-1:0] W_MAX  = SW'(ccpe_pkg::WEIGHT_LIMIT);
	localparam logic signed [SW-1:0] W_MIN  = -W_MAX;

	logic en_s4, en_s5;
	logic v_s4, v_s5;

	logic signed [PW-1:0]          prod_d  [4][4];
	logic signed [PW-1:0]          prod_s4 [4][4];
	logic signed [COORD_WIDTH-1:0] coord_s4 [4];

	logic signed [SW-1:0]          wsum [4];
	logic signed [SW-1:0]          wrnd [4];
	logic signed [WW-1:0]          w_d  [4];
	logic signed [WW-1:0]          w_s5 [4];
	logic signed [COORD_WIDTH-1:0] coord_s5 [4];

	// Stage enables
	assign en_s5    = !v_s5 || dn_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign up_ready = en_s4;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s4) begin
				v_s4 <= up_valid;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	// Stage 4: one product per matrix entry, indexed [control point][power row]
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				prod_d[i][j] = PW'(uv[j])
					* PW'(ccpe_pkg::basis_coef(basis_sel, 2'(j), 2'(i)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			prod_s4  <= prod_d;
			coord_s4 <= coord;
		end
	end

	// Stage 5: sum the column, round half up and clamp each weight
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			wsum[i] = SW'(prod_s4[i][0]) + SW'(prod_s4[i][1])
				+ SW'(prod_s4[i][2]) + SW'(prod_s4[i][3]);
			wrnd[i] = (wsum[i] + W_HALF) >>> F;
			if (wrnd[i] > W_MAX) begin
				w_d[i] = WW'(W_MAX);
			end else if (wrnd[i] < W_MIN) begin
				w_d[i] = WW'(W_MIN);
			end else begin
				w_d[i] = WW'(wrnd[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			w_s5     <= w_d;
			coord_s5 <= coord_s4;
		end
	end

	assign dn_valid  = v_s5;
	assign weight    = w_s5;
	assign coord_out = coord_s5;

endmodule

`default_nettype wire

@@ rtl/ccpe_blend.sv @@
// ----------------------------------------------------------------------------
// ccpe_blend: control point blend stages
// Weights the four control coordinates, sums, rounds out of Q.16 and
// saturates the result to 32 bits into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpe_blend #(
	parameter int COORD_WIDTH = ccpe_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 up_valid,
	output logic                                      up_ready,
	input  wire logic signed [ccpe_pkg::WEIGHT_W-1:0] weight [4],
	input  wire logic signed [COORD_WIDTH-1:0]        coord [4],
	output logic                                      dn_valid,
	input  wire logic                                 dn_ready,
	output logic signed [ccpe_pkg::VALUE_W-1:0]       value
);

	localparam int WW  = ccpe_pkg::WEIGHT_W;
	localparam int WPW = WW + COORD_WIDTH;
	localparam int AW  = WPW + 2;
	localparam int OW  = ccpe_pkg::VALUE_W;

	localparam logic signed [AW-1:0] A_HALF  = AW'(1) <<< (ccpe_pkg::MAT_FRAC - 1);
	localparam logic signed [AW-1:0] OUT_MAX = AW'(32'sh7FFF_FFFF);
	localparam logic signed [AW-1:0] OUT_MIN = AW'(32'sh8000_0000);

	logic en_s6, en_s7;
	logic v_s6, v_s7;

	logic signed [WPW-1:0] wp_d  [4];
	logic signed [WPW-1:0] wp_s6 [4];
	logic signed [AW-1:0]  acc;
	logic signed [AW-1:0]  acc_rnd;
	logic signed [OW-1:0]  value_d;
	logic signed [OW-1:0]  value_s7;

	// Stage enables
	assign en_s7    = !v_s7 || dn_ready;
	assign en_s6    = !v_s6 || en_s7;
	assign up_ready = en_s6;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s6) begin
				v_s6 <= up_valid;
			end
			if (en_s7) begin
				v_s7 <= v_s6;
			end
		end
	end

	// Stage 6: weight each control coordinate
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			wp_d[i] = WPW'(weight[i]) * WPW'(coord[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			wp_s6 <= wp_d;
		end
	end

	// Stage 7: sum, round out of Q.16 and saturate
	assign acc     = AW'(wp_s6[0]) + AW'(wp_s6[1]) + AW'(wp_s6[2]) + AW'(wp_s6[3]);
	assign acc_rnd = (acc + A_HALF) >>> ccpe_pkg::MAT_FRAC;

	always_comb begin
		if (acc_rnd > OUT_MAX) begin
			value_d = OW'(OUT_MAX);
		end else if (acc_rnd < OUT_MIN) begin
			value_d = OW'(OUT_MIN);
		end else begin
			value_d = OW'(acc_rnd);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			value_s7 <= value_d;
		end
	end

	assign dn_valid = v_s7;
	assign value    = value_s7;

endmodule

`default_nettype wire

@@ rtl/cubic_curve_point_eval_top.sv @@
// Throughput: one beat per cycle while the output is not stalled; seven pipeline
// registers, each a stage that holds on its own when the output is stalled and
// fills any bubble ahead.
// Reset clears all stage valid bits and sets the basis register to B-spline.
// ----------------------------------------------------------------------------
// cubic_curve_point_eval_top: cubic curve point evaluator
// Evaluates one axis of a cubic segment as U(u) * M * P for the selected
// basis matrix and derivative order, result in saturated signed Q32.0 at the coordinate scale.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_curve_point_eval_top #(
	parameter int COORD_WIDTH     = ccpe_pkg::COORD_WIDTH_DEF,
	parameter int PARAM_FRAC_BITS = ccpe_pkg::PARAM_FRAC_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_write_en,
	input  wire logic [ccpe_pkg::BASIS_W-1:0]         cfg_write_data,
	input  wire logic                                 item_valid,
	output logic                                      item_stall,
	input  wire logic [PARAM_FRAC_BITS:0]             param_u,
	input  wire logic [1:0]                           deriv_order,
	input  wire logic signed [COORD_WIDTH-1:0]        ctrl_a,
	input  wire logic signed [COORD_WIDTH-1:0]        ctrl_b,
	input  wire logic signed [COORD_WIDTH-1:0]        ctrl_c,
	input  wire logic signed [COORD_WIDTH-1:0]        ctrl_d,
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output logic signed [ccpe_pkg::VALUE_W-1:0]       curve_value
);

	logic [ccpe_pkg::BASIS_W-1:0] basis_q;

	logic signed [COORD_WIDTH-1:0] coord_in [4];

	logic                                 pw_ready, pw_valid;
	logic signed [PARAM_FRAC_BITS+4:0]    pw_uv [4];
	logic signed [COORD_WIDTH-1:0]        pw_coord [4];
	logic [ccpe_pkg::BASIS_W-1:0]         pw_basis;

	logic                                 wt_ready, wt_valid;
	logic signed [ccpe_pkg::WEIGHT_W-1:0] wt_weight [4];
	logic signed [COORD_WIDTH-1:0]        wt_coord [4];

	logic                                 bl_ready;

	// Basis select register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			basis_q <= ccpe_pkg::BASIS_BSPLINE;
		end else if (cfg_write_en) begin
			basis_q <= cfg_write_data;
		end
	end

	assign coord_in[0] = ctrl_a;
	assign coord_in[1] = ctrl_b;
	assign coord_in[2] = ctrl_c;
	assign coord_in[3] = ctrl_d;

	ccpe_power #(
		.COORD_WIDTH     (COORD_WIDTH),
		.PARAM_FRAC_BITS (PARAM_FRAC_BITS)
	) u_power (
		.clk         (clk),
		.arst_n      (arst_n),
		.up_valid    (item_valid),
		.up_ready    (pw_ready),
		.param_u     (param_u),
		.deriv_order (deriv_order),
		.coord       (coord_in),
		.basis_sel   (basis_q),
		.dn_valid    (pw_valid),
		.dn_ready    (wt_ready),
		.uv          (pw_uv),
		.coord_out   (pw_coord),
		.basis_out   (pw_basis)
	);

	ccpe_weight #(
		.COORD_WIDTH     (COORD_WIDTH),
		.PARAM_FRAC_BITS (PARAM_FRAC_BITS)
	) u_weight (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (pw_valid),
		.up_ready  (wt_ready),
		.uv        (pw_uv),
		.coord     (pw_coord),
		.basis_sel (pw_basis),
		.dn_valid  (wt_valid),
		.dn_ready  (bl_ready),
		.weight    (wt_weight),
		.coord_out (wt_coord)
	);

	ccpe_blend #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (wt_valid),
		.up_ready (bl_ready),
		.weight   (wt_weight),
		.coord    (wt_coord),
		.dn_valid (result_valid),
		.dn_ready (!result_stall),
		.value    (curve_value)
	);

	assign item_stall = !pw_ready;

	// A free output side lets the whole pipeline advance
	a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!result_stall |-> !item_stall)
		else $error("input stalled while the output side is free");

	// The input only stalls when a result waits at a stalled output
	a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("input stalled without a waiting result");

	// A stalled result stays put, and the pipeline behind it keeps its beats
	a_stalled_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall && item_stall) |=> result_valid && item_stall
			|| !result_stall)
		else $error("pipeline dropped a beat while stalled");

endmodule

`default_nettype wire

@@ bench/curve_value_checker.sv @@
// ----------------------------------------------------------------------------
// curve_value_checker: scoreboard for the cubic curve point evaluator
// Watches the basis register writes and both beat channels, computes the
// expected curve value of every accepted input beat and compares it with the
// result beats in order.
// ----------------------------------------------------------------------------

module curve_value_checker (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             cfg_write_en,
	input  logic [ccpe_pkg::BASIS_W-1:0]                     cfg_write_data,
	input  logic                                             item_valid,
	input  logic                                             item_stall,
	input  logic [ccpe_pkg::PARAM_FRAC_BITS_DEF:0]           param_u,
	input  logic [1:0]                                       deriv_order,
	input  logic signed [ccpe_pkg::COORD_WIDTH_DEF-1:0]      ctrl_a,
	input  logic signed [ccpe_pkg::COORD_WIDTH_DEF-1:0]      ctrl_b,
	input  logic signed [ccpe_pkg::COORD_WIDTH_DEF-1:0]      ctrl_c,
	input  logic signed [ccpe_pkg::COORD_WIDTH_DEF-1:0]      ctrl_d,
	input  logic                                             result_valid,
	input  logic                                             result_stall,
	input  logic signed [ccpe_pkg::VALUE_W-1:0]              curve_value,
	output int unsigned                                      mismatch_count,
	output int unsigned                                      pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import ccpe_pkg::*;

	localparam int  U_FRAC    = PARAM_FRAC_BITS_DEF;
	localparam int  U_W       = PARAM_FRAC_BITS_DEF + 1;
	localparam int  C_W       = COORD_WIDTH_DEF;
	localparam longint W_CLAMP = longint'(1) << 29;

	// Q.16 basis coefficients, [basis][power row][control point]
	localparam int COEF_Q16 [5][4][4] = '{
		'{ '{ -294912,   884736,  -884736,  294912 },
		   '{  589824, -1474560,  1179648, -294912 },
		   '{ -360448,   589824,  -294912,   65536 },
		   '{   65536,        0,        0,       0 } },
		'{ '{  131072,  -131072,    65536,   65536 },
		   '{ -196608,   196608,  -131072,  -65536 },
		   '{       0,        0,    65536,       0 },
		   '{   65536,        0,        0,       0 } },
		'{ '{  -65536,   196608,  -196608,   65536 },
		   '{  196608,  -393216,   196608,       0 },
		   '{ -196608,   196608,        0,       0 },
		   '{   65536,        0,        0,       0 } },
		'{ '{  -32768,    98304,   -98304,   32768 },
		   '{   65536,  -163840,   131072,  -32768 },
		   '{  -32768,        0,    32768,       0 },
		   '{       0,    65536,        0,       0 } },
		'{ '{  -10923,    32768,   -32768,   10923 },
		   '{   32768,   -65536,    32768,       0 },
		   '{  -32768,        0,    32768,       0 },
		   '{   10923,    43691,    10923,       0 } }
	};

	logic [BASIS_W-1:0]          basis_reg = BASIS_BSPLINE;
	logic signed [VALUE_W-1:0]   curve_value_q[$];
	int unsigned                 fails = 0;
	int unsigned                 waiting = 0;

	assign mismatch_count = fails;
	assign pending_count  = waiting;

	// Round half towards plus infinity, then floor divide by 2^s
	function automatic longint round_down_shift(longint x, int s);
		return (x + (longint'(1) << (s - 1))) >>> s;
	endfunction

	// Expected curve value of one input beat under the given basis code
	function automatic logic signed [VALUE_W-1:0] eval_curve_point(
		logic [BASIS_W-1:0]        sel,
		logic [U_W-1:0]            u_in,
		logic [1:0]                ord,
		logic signed [C_W-1:0]     pa,
		logic signed [C_W-1:0]     pb,
		logic signed [C_W-1:0]     pc,
		logic signed [C_W-1:0]     pd
	);
		longint u, u2, u3, w, acc, one;
		longint pow_vec[4];
		longint pt[4];
		int     m;
		u   = longint'(u_in);
		one = longint'(1) << U_FRAC;
		u2  = round_down_shift(u * u, U_FRAC);
		u3  = round_down_shift(u2 * u, U_FRAC);
		if (ord == ORDER_POSITION) begin
			pow_vec = '{u3, u2, u, one};
		end else if (ord == ORDER_FIRST) begin
			pow_vec = '{3 * u2, 2 * u, one, 0};
		end else begin
			// third order folds onto the second
			pow_vec = '{6 * u, 2 * one, 0, 0};
		end
		pt[0] = longint'(pa);
		pt[1] = longint'(pb);
		pt[2] = longint'(pc);
		pt[3] = longint'(pd);
		// codes past the last basis fall back to the B-spline
		m   = (sel > BASIS_BSPLINE) ? int'(BASIS_BSPLINE) : int'(sel);
		acc = 0;
		for (int i = 0; i < 4; i++) begin
			w = 0;
			for (int j = 0; j < 4; j++)
				w += pow_vec[j] * longint'(COEF_Q16[m][j][i]);
			w = round_down_shift(w, U_FRAC);
			if (w > W_CLAMP)
				w = W_CLAMP;
			if (w < -W_CLAMP)
				w = -W_CLAMP;
			acc += w * pt[i];
		end
		acc = round_down_shift(acc, MAT_FRAC);
		if (acc > longint'(32'sh7fffffff))
			acc = longint'(32'sh7fffffff);
		if (acc < longint'(32'sh80000000))
			acc = longint'(32'sh80000000);
		return VALUE_W'(acc);
	endfunction

	// Check result beats, queue predictions for input beats, track the register
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			basis_reg = BASIS_BSPLINE;
			curve_value_q.delete();
			waiting = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (curve_value_q.size() == 0) begin
					$error("curve_value: expected none, actual %0d", curve_value);
					fails++;
				end else begin
					logic signed [VALUE_W-1:0] want;
					want = curve_value_q.pop_front();
					if (curve_value !== want) begin
						$error("curve_value: expected %0d, actual %0d", want, curve_value);
						fails++;
					end
				end
			end
			if (item_valid && !item_stall)
				curve_value_q = {curve_value_q, eval_curve_point(basis_reg, param_u,
					deriv_order, ctrl_a, ctrl_b, ctrl_c, ctrl_d)};
			if (cfg_write_en)
				basis_reg = cfg_write_data;
			waiting = curve_value_q.size();
		end
	end

endmodule

@@ bench/cubic_curve_point_eval_top_tb.sv @@
// ----------------------------------------------------------------------------
// cubic_curve_point_eval_top_tb: testbench for the cubic curve point evaluator
// Drives directed corner beats, then random beats under every basis code
// with random idling on both channels; a checker beside the block predicts
// and compares each result, and a watchdog ends a hung run.
// ----------------------------------------------------------------------------

module cubic_curve_point_eval_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ccpe_pkg::*;

	localparam int U_W          = PARAM_FRAC_BITS_DEF + 1;
	localparam int C_W          = COORD_WIDTH_DEF;
	localparam int PIPE_LATENCY = 7;
	localparam int QUIET_LIMIT  = 1000;
	localparam int PHASE_ITEMS  = 140;
	localparam int NUM_PHASES   = 10;

	localparam logic [1:0] ORDER_SECOND = 2'd2;
	localparam logic [1:0] ORDER_THIRD  = 2'd3;

	// Basis codes beyond the defined matrices
	localparam logic [BASIS_W-1:0] BASIS_RSVD5 = 3'd5;
	localparam logic [BASIS_W-1:0] BASIS_RSVD6 = 3'd6;
	localparam logic [BASIS_W-1:0] BASIS_RSVD7 = 3'd7;

	localparam logic [U_W-1:0]        U_ZERO = '0;
	localparam logic [U_W-1:0]        U_ONE  = U_W'(1) << PARAM_FRAC_BITS_DEF;
	localparam logic [U_W-1:0]        U_HALF = U_W'(1) << (PARAM_FRAC_BITS_DEF - 1);
	localparam logic [U_W-1:0]        U_TOP  = '1;
	localparam logic signed [C_W-1:0] C_MAX  = {1'b0, {(C_W-1){1'b1}}};
	localparam logic signed [C_W-1:0] C_MIN  = {1'b1, {(C_W-1){1'b0}}};

	localparam logic [BASIS_W-1:0] PHASE_BASIS [NUM_PHASES] = '{
		BASIS_INTERP, BASIS_HERMITE, BASIS_BEZIER, BASIS_CATMULL, BASIS_RSVD7,
		BASIS_RSVD5, BASIS_RSVD6, BASIS_BSPLINE, BASIS_BEZIER, BASIS_INTERP
	};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_write_en = 1'b0;
	logic [BASIS_W-1:0]       cfg_write_data = '0;
	logic                     item_valid = 1'b0;
	logic                     item_stall;
	logic [U_W-1:0]           param_u = '0;
	logic [1:0]               deriv_order = '0;
	logic signed [C_W-1:0]    ctrl_a = '0;
	logic signed [C_W-1:0]    ctrl_b = '0;
	logic signed [C_W-1:0]    ctrl_c = '0;
	logic signed [C_W-1:0]    ctrl_d = '0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	logic signed [VALUE_W-1:0] curve_value;

	int unsigned mismatch_count;
	int unsigned pending_count;
	int unsigned beats_sent = 0;
	int unsigned quiet_cycles = 0;
	bit          quiet_tail = 1'b0;

	cubic_curve_point_eval_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.param_u        (param_u),
		.deriv_order    (deriv_order),
		.ctrl_a         (ctrl_a),
		.ctrl_b         (ctrl_b),
		.ctrl_c         (ctrl_c),
		.ctrl_d         (ctrl_d),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.curve_value    (curve_value)
	);

	curve_value_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.param_u        (param_u),
		.deriv_order    (deriv_order),
		.ctrl_a         (ctrl_a),
		.ctrl_b         (ctrl_b),
		.ctrl_c         (ctrl_c),
		.ctrl_d         (ctrl_d),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.curve_value    (curve_value),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	// 20 ns clock
	initial begin
		forever #10 clk = ~clk;
	end

	// Stall the result channel in random bursts; hold it open in the tail
	initial begin
		int unsigned burst;
		forever begin
			if (quiet_tail) begin
				@(negedge clk);
				result_stall <= 1'b0;
			end else begin
				burst = $urandom_range(1, 17);
				@(negedge clk);
				result_stall <= ($urandom_range(0, 2) == 0);
				repeat (burst - 1) @(negedge clk);
			end
		end
	end

	// End a run in which no beat moves for too long
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Present one input beat and hold it until accepted
	task automatic send_item(
		input logic [U_W-1:0]        u,
		input logic [1:0]            ord,
		input logic signed [C_W-1:0] a,
		input logic signed [C_W-1:0] b,
		input logic signed [C_W-1:0] c,
		input logic signed [C_W-1:0] d
	);
		@(negedge clk);
		item_valid  <= 1'b1;
		param_u     <= u;
		deriv_order <= ord;
		ctrl_a      <= a;
		ctrl_b      <= b;
		ctrl_c      <= c;
		ctrl_d      <= d;
		do
			@(posedge clk);
		while (item_stall);
		beats_sent++;
	endtask

	// Drop valid for a gap whose length is given by n
	task automatic pause_sender(input int unsigned n);
		@(negedge clk);
		item_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// Drop valid and wait until every result beat is back, then settle
	task automatic drain_block();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (PIPE_LATENCY + 2) @(negedge clk);
	endtask

	// Write the basis register while the block is idle
	task automatic write_basis(input logic [BASIS_W-1:0] code);
		drain_block();
		cfg_write_en   <= 1'b1;
		cfg_write_data <= code;
		@(negedge clk);
		cfg_write_en   <= 1'b0;
	endtask

	// Coordinate mix: extremes, small values around zero, full range
	function automatic logic signed [C_W-1:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return C_MAX;
			1: return C_MIN;
			2, 3: return C_W'($signed($urandom_range(0, 1023)) - 512);
			default: return C_W'($urandom);
		endcase
	endfunction

	// One random beat, sometimes after a gap
	task automatic send_random_item();
		logic [U_W-1:0] u;
		logic [1:0]     ord;
		if (!quiet_tail && $urandom_range(0, 3) == 0)
			pause_sender($urandom_range(1, 17));
		case ($urandom_range(0, 9))
			0: u = U_ZERO;
			1: u = U_ONE;
			2: u = U_W'($urandom_range(0, (1 << U_W) - 1));
			3: u = U_W'($urandom_range(0, 255));
			default: u = U_W'($urandom_range(0, 1 << PARAM_FRAC_BITS_DEF));
		endcase
		ord = ($urandom_range(0, 7) == 0) ? ORDER_THIRD : 2'($urandom_range(0, 2));
		send_item(u, ord, rand_coord(), rand_coord(), rand_coord(), rand_coord());
	endtask

	// Main stimulus
	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Directed corners under the reset basis
		send_item(U_ZERO, ORDER_POSITION, C_MAX, C_MAX, C_MAX, C_MAX);
		send_item(U_ZERO, ORDER_POSITION, C_MIN, C_MIN, C_MIN, C_MIN);
		send_item(U_ONE,  ORDER_POSITION, C_MAX, C_MIN, C_MAX, C_MIN);
		send_item(U_TOP,  ORDER_POSITION, C_MIN, C_MAX, C_MIN, C_MAX);
		send_item(U_TOP,  ORDER_POSITION, C_MAX, C_MAX, C_MAX, C_MAX);
		send_item(U_W'(1), ORDER_POSITION, C_MAX, '0, C_MIN, '0);
		send_item(U_HALF, ORDER_POSITION, C_MAX, C_MIN, C_MIN, C_MAX);
		send_item(U_ZERO, ORDER_FIRST,    C_MIN, C_MAX, C_MAX, C_MIN);
		send_item(U_ONE,  ORDER_FIRST,    C_MAX, C_MIN, C_MAX, C_MIN);
		send_item(U_TOP,  ORDER_FIRST,    C_MIN, C_MIN, C_MIN, C_MIN);
		send_item(U_HALF, ORDER_FIRST,    '0, C_MAX, '0, C_MIN);
		send_item(U_ZERO, ORDER_SECOND,   C_MAX, C_MIN, C_MAX, C_MIN);
		send_item(U_ONE,  ORDER_SECOND,   C_MIN, C_MAX, C_MIN, C_MAX);
		send_item(U_TOP,  ORDER_SECOND,   C_MAX, C_MAX, C_MIN, C_MIN);
		send_item(U_HALF, ORDER_SECOND,   C_MIN, C_MIN, C_MAX, C_MAX);
		// order three must behave as order two
		send_item(U_HALF, ORDER_THIRD,    C_MIN, C_MIN, C_MAX, C_MAX);
		send_item(U_TOP,  ORDER_THIRD,    C_MAX, C_MAX, C_MIN, C_MIN);
		send_item(U_ONE,  ORDER_THIRD,    16'sh0100, 16'sh0200, 16'sh0300, 16'sh0400);
		send_item(U_W'(16'h5555), ORDER_POSITION, 16'sh5555, -16'sh2aab, 16'sh0001, -16'sh0001);
		send_item(U_W'(17'h1aaaa), ORDER_FIRST, -16'sh5556, 16'sh2aaa, -16'sh0001, 16'sh0001);

		// Random phases, one basis code each; the last runs with no idling
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_basis(PHASE_BASIS[ph]);
			quiet_tail = (ph == NUM_PHASES - 1);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// hold the sender once until the pipeline is empty
				if (ph == 3 && k == PHASE_ITEMS / 2)
					drain_block();
				send_random_item();
			end
		end

		drain_block();
		repeat (PIPE_LATENCY + 8) @(negedge clk);

		$display("Covered %0d beats: every basis code 0 to 7, derivative orders 0 to 3,",
			beats_sent);
		$display("u from 0 past 1.0, extreme coordinates, random stalls and gaps");
		if (mismatch_count == 0 && pending_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
